/* design/uf_pkg.sv */
// Shared types and constants for the disjoint-set block with element moves.
// Used by the core and the top level; depends on nothing.
package uf_pkg;

  // Largest element count the forest is built for.
  localparam int MAX_ELEMS  = 1024;
  // Elements plus virtual roots plus the unused node zero.
  localparam int NODE_COUNT = 2 * MAX_ELEMS + 1;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(MAX_ELEMS + 1);

  // Field widths fixed by the interface.
  localparam int ELEM_W = 11;
  localparam int SIZE_W = 11;
  localparam int SUM_W  = 20;
  localparam int OP_W   = 2;

  // Request codes; any other code acts as a query.
  localparam logic [OP_W-1:0] REQ_UNITE = 2'd0;
  localparam logic [OP_W-1:0] REQ_MOVE  = 2'd1;
  localparam logic [OP_W-1:0] REQ_QUERY = 2'd2;

  // One node entry as held in the node memory.
  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [SIZE_W-1:0] size;
    logic [SUM_W-1:0]  sum;
  } node_ent_t;

  typedef struct packed {
    logic [OP_W-1:0]   req_type;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
  } req_t;

  typedef struct packed {
    logic              changed;
    logic [SIZE_W-1:0] set_size;
    logic [SUM_W-1:0]  set_sum;
    logic              bad_request;
  } res_t;

endpackage

/* design/uf_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; a read of the address written in the same cycle returns old data.
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/uf_core.sv */
// Request sequencer for the disjoint-set forest: clearing pass, root finds with
// path compression, and the unite and move updates. Depends on uf_pkg and uf_ram.
module uf_core
  import uf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [ELEM_W-1:0] cfg_data,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              res_valid,
  input  logic              res_take,
  output res_t              res
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FIND  = 6'b000100,
    S_COMP  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [NODE_W-1:0]  clr_r, clr_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [NODE_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt, top_r, top_nxt;
  logic               phase_b_r, phase_b_nxt;
  logic [NODE_W-1:0]  ra_r, ra_nxt, rb_r, rb_nxt;
  logic [SIZE_W-1:0]  sa_r, sa_nxt, sb_r, sb_nxt;
  logic [SUM_W-1:0]   ua_r, ua_nxt, ub_r, ub_nxt;
  logic [1:0]         wcnt_r, wcnt_nxt;
  res_t               res_r, res_nxt;

  logic               we;
  logic [NODE_W-1:0]  waddr, raddr;
  node_ent_t          wdata, rdata;

  logic [NODE_W-1:0]  n_ext, two_n, in_a, in_b;
  logic [ELEM_W-1:0]  cfg_clamped;
  logic               uses_b, in_bad, is_query, same, swap;
  logic [NODE_W-1:0]  big, small_root;
  logic [SIZE_W-1:0]  small_size;
  logic [SUM_W-1:0]   small_sum;
  logic [1:0]         nw;

  uf_ram #(.WIDTH($bits(node_ent_t)), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Helper values for the request checks and the updates.
  always_comb begin
    n_ext  = NODE_W'(n_r);
    two_n  = NODE_W'({n_r, 1'b0});
    in_a   = NODE_W'(req.elem_a);
    in_b   = NODE_W'(req.elem_b);
    uses_b = (req.req_type == REQ_UNITE) || (req.req_type == REQ_MOVE);
    in_bad = (in_a == '0) || (in_a > n_ext) ||
             (uses_b && ((in_b == '0) || (in_b > n_ext)));
    if (cfg_data == '0) begin
      cfg_clamped = ELEM_W'(1);
    end else if (int'(cfg_data) > MAX_ELEMS) begin
      cfg_clamped = ELEM_W'(MAX_ELEMS);
    end else begin
      cfg_clamped = cfg_data;
    end
    is_query   = !((op_r == REQ_UNITE) || (op_r == REQ_MOVE));
    same       = (ra_r == rb_r);
    swap       = (sa_r < sb_r);
    big        = swap ? rb_r : ra_r;
    small_root = swap ? ra_r : rb_r;
    small_size = swap ? sa_r : sb_r;
    small_sum  = swap ? ua_r : ub_r;
    if (is_query || same) begin
      nw = 2'd0;
    end else if (op_r == REQ_UNITE) begin
      nw = 2'd2;
    end else begin
      nw = 2'd3;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    clr_nxt     = clr_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    cur_nxt     = cur_r;
    top_nxt     = top_r;
    phase_b_nxt = phase_b_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    sa_nxt      = sa_r;
    sb_nxt      = sb_r;
    ua_nxt      = ua_r;
    ub_nxt      = ub_r;
    wcnt_nxt    = wcnt_r;
    res_nxt     = res_r;
    we          = 1'b0;
    waddr       = clr_r;
    wdata       = '0;
    raddr       = cur_r;

    case (state_r)
      // Rebuild the initial forest over nodes 1..2n, one entry a cycle.
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r <= n_ext) begin
          wdata = '{parent: clr_r + n_ext, size: SIZE_W'(1), sum: SUM_W'(clr_r)};
        end else begin
          wdata = '{parent: clr_r, size: SIZE_W'(1), sum: SUM_W'(clr_r - n_ext)};
        end
        if (clr_r == two_n) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + NODE_W'(1);
        end
      end
      // Take a request; the read of element a goes out in the same cycle.
      S_IDLE: begin
        if (req_valid) begin
          op_nxt = req.req_type;
          a_nxt  = in_a;
          b_nxt  = in_b;
          if (in_bad) begin
            res_nxt   = '{changed: 1'b0, set_size: '0, set_sum: '0, bad_request: 1'b1};
            state_nxt = S_DONE;
          end else begin
            raddr       = in_a;
            cur_nxt     = in_a;
            phase_b_nxt = 1'b0;
            state_nxt   = S_FIND;
          end
        end
      end
      // Walk parent links, one per cycle, until a node points to itself.
      S_FIND: begin
        if (rdata.parent == cur_r) begin
          top_nxt = cur_r;
          if (phase_b_r) begin
            rb_nxt = cur_r;
            sb_nxt = rdata.size;
            ub_nxt = rdata.sum;
            raddr  = b_r;
            cur_nxt = b_r;
          end else begin
            ra_nxt = cur_r;
            sa_nxt = rdata.size;
            ua_nxt = rdata.sum;
            raddr  = a_r;
            cur_nxt = a_r;
          end
          state_nxt = S_COMP;
        end else begin
          cur_nxt = rdata.parent;
          raddr   = rdata.parent;
        end
      end
      // Second pass: point every node of the path at the root.
      S_COMP: begin
        if (cur_r == top_r) begin
          if (!phase_b_r && !is_query) begin
            phase_b_nxt = 1'b1;
            cur_nxt     = b_r;
            raddr       = b_r;
            state_nxt   = S_FIND;
          end else begin
            wcnt_nxt  = 2'd0;
            state_nxt = S_WRITE;
          end
        end else begin
          we      = 1'b1;
          waddr   = cur_r;
          wdata   = '{parent: top_r, size: rdata.size, sum: rdata.sum};
          cur_nxt = rdata.parent;
          raddr   = rdata.parent;
        end
      end
      // Write back the updated roots (and, for a move, element a), then form the result.
      S_WRITE: begin
        if (wcnt_r == nw) begin
          if (is_query || same) begin
            res_nxt = '{changed: 1'b0, set_size: sa_r, set_sum: ua_r, bad_request: 1'b0};
          end else if (op_r == REQ_UNITE) begin
            res_nxt = '{changed: 1'b1, set_size: sa_r + sb_r, set_sum: ua_r + ub_r,
                        bad_request: 1'b0};
          end else begin
            res_nxt = '{changed: 1'b1, set_size: sb_r + SIZE_W'(1),
                        set_sum: ub_r + SUM_W'(a_r), bad_request: 1'b0};
          end
          state_nxt = S_DONE;
        end else begin
          we       = 1'b1;
          wcnt_nxt = wcnt_r + 2'd1;
          if (op_r == REQ_UNITE) begin
            if (wcnt_r == 2'd0) begin
              waddr = small_root;
              wdata = '{parent: big, size: small_size, sum: small_sum};
            end else begin
              waddr = big;
              wdata = '{parent: big, size: sa_r + sb_r, sum: ua_r + ub_r};
            end
          end else begin
            case (wcnt_r)
              2'd0: begin
                waddr = ra_r;
                wdata = '{parent: ra_r, size: sa_r - SIZE_W'(1), sum: ua_r - SUM_W'(a_r)};
              end
              2'd1: begin
                waddr = a_r;
                wdata = '{parent: rb_r, size: SIZE_W'(1), sum: SUM_W'(a_r)};
              end
              default: begin
                waddr = rb_r;
                wdata = '{parent: rb_r, size: sb_r + SIZE_W'(1), sum: ub_r + SUM_W'(a_r)};
              end
            endcase
          end
        end
      end
      // Hold the result until the output register takes it.
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = NODE_W'(1);
      end
    endcase

    // A write of the element count restarts the clearing pass.
    if (cfg_valid) begin
      n_nxt     = CNT_W'(cfg_clamped);
      clr_nxt   = NODE_W'(1);
      state_nxt = S_CLEAR;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      n_r     <= CNT_W'(MAX_ELEMS);
      clr_r   <= NODE_W'(1);
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    cur_r     <= cur_nxt;
    top_r     <= top_nxt;
    phase_b_r <= phase_b_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    sa_r      <= sa_nxt;
    sb_r      <= sb_nxt;
    ua_r      <= ua_nxt;
    ub_r      <= ub_nxt;
    wcnt_r    <= wcnt_nxt;
    res_r     <= res_nxt;
  end

endmodule

/* design/union_find_with_move.sv */
// Top level of the disjoint-set block with element moves: stream ports and the
// output register. Depends on uf_pkg and uf_core.
//
// Usage:
//   in_*  carries one request per transfer: in_tuser is the request type
//   (0 unite, 1 move a into b's set, 2 or 3 query), in_tdata the two elements.
//   out_* carries one result per request, in order: changed flag, size and
//   element sum of a's set after the request, and bad_request in out_tuser.
//   cfg_* writes the element count (0 acts as 1, values above 1024 as 1024).
// Operation:
//   One request at a time. A bad request goes straight to its result, with no find.
//   Otherwise the find for a walks a's path and then compresses it, the find
//   for b does as much again for a unite or a move, then the updated roots are
//   written back through the single node-memory write port.
// Reset and configuration:
//   After reset, and after every element count write, a clearing pass writes
//   nodes 1..2n one per cycle (nodes 1..2048 at reset); in_tready stays low.
// Stalls:
//   A result waits in the output register while out_tready is low; the next
//   request is still accepted and worked on meanwhile.
module union_find_with_move
  import uf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ELEM_W-1:0] cfg_data,   // elem_count
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // elem_a[10:0], elem_b[21:11], zero pad
  input  logic [1:0]        in_tuser,   // req_type[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // changed[0], set_size[11:1], set_sum[31:12]
  output logic              out_tuser   // bad_request
);

  req_t       req;
  res_t       res;
  logic       res_valid, res_take;
  logic       out_valid_r;
  logic [31:0] out_data_r;
  logic       out_user_r;

  assign cfg_ready = 1'b1;

  // Unpack the request.
  assign req = '{req_type: in_tuser, elem_a: in_tdata[10:0], elem_b: in_tdata[21:11]};

  uf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // The result moves on when the output register is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= {res.set_sum, res.set_size, res.changed};
      out_user_r <= res.bad_request;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* design/uf_checker.sv */
// Port-level checker for the disjoint-set block, with its bind statement.
// Depends on the top level's ports only.
module uf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A bad request carries zero fields.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("bad request result has nonzero fields");

  // A good result names a set of at least one element.
  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[11:1] != 11'd0)
    else $error("good result with empty set");

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // A count write starts the clearing pass.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("request taken during rebuild");

endmodule

bind union_find_with_move uf_checker u_uf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
